// ===== rtl/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame decoder.
// No dependencies; imported by every module of the block.
package lpfd_pkg;

  // Escape byte that announces a multi-byte length
  localparam logic [7:0] EscapeByte = 8'hff;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_OVER  = 2'd3
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] body_byte;
    logic [7:0] frame_flags;
    logic       first_byte;
    logic       last_byte;
  } result_t;

endpackage

// ===== rtl/lpfd_parser.sv =====
// Frame parser: state registers and per-byte decode, one byte per cycle while accept_i is high.
// Holds the max body length register. Depends on lpfd_pkg.
module lpfd_parser import lpfd_pkg::*; #(
  parameter int unsigned LONG_LENGTH_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  stream_byte_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam logic [1:0] PhLen   = 2'd0;
  localparam logic [1:0] PhLong  = 2'd1;
  localparam logic [1:0] PhFlags = 2'd2;
  localparam logic [1:0] PhBody  = 2'd3;

  // count of long length bytes, modulo 8 (eight bytes wrap to zero)
  localparam logic [2:0] LongCnt = 3'(LONG_LENGTH_BYTES % 8);

  logic [1:0]  phase_q, phase_d;
  logic [63:0] shift_q, shift_d;
  logic [2:0]  seen_q, seen_d;
  logic [63:0] remain_q, remain_d;
  logic [7:0]  flags_q, flags_d;
  logic        first_q, first_d;
  // max body length plus one, kept 65 bits wide so the limit compare is a single compare
  logic [64:0] max_p1_q;

  logic [63:0] shift_n;
  logic [2:0]  seen_n;
  logic [63:0] len_sel;
  logic        len_done;

  assign shift_n = {shift_q[55:0], stream_byte_i};
  assign seen_n  = seen_q + 3'd1;
  assign len_sel = (phase_q == PhLen) ? {56'd0, stream_byte_i} : shift_n;

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    seen_d      = seen_q;
    remain_d    = remain_q;
    flags_d     = flags_q;
    first_d     = first_q;
    len_done    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_BODY, body_byte: 8'd0, frame_flags: 8'd0,
                    first_byte: 1'b0, last_byte: 1'b0};

    case (phase_q)
      PhLen: begin
        if (stream_byte_i == EscapeByte) begin
          shift_d = 64'd0;
          seen_d  = 3'd0;
          phase_d = PhLong;
        end else begin
          len_done = 1'b1;
        end
      end
      PhLong: begin
        shift_d = shift_n;
        if (seen_n == LongCnt) begin
          seen_d   = 3'd0;
          len_done = 1'b1;
        end else begin
          seen_d = seen_n;
        end
      end
      PhFlags: begin
        flags_d = stream_byte_i;
        if (remain_q == 64'd0) begin
          phase_d           = PhLen;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_EMPTY;
          res_o.frame_flags = stream_byte_i;
          res_o.last_byte   = 1'b1;
        end else begin
          first_d = 1'b1;
          phase_d = PhBody;
        end
      end
      default: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_BODY;
        res_o.body_byte   = stream_byte_i;
        res_o.frame_flags = flags_q;
        res_o.first_byte  = first_q;
        res_o.last_byte   = (remain_q <= 64'd1);
        first_d           = 1'b0;
        if (remain_q != 64'd0) begin
          remain_d = remain_q - 64'd1;
        end
        if (remain_q <= 64'd1) begin
          phase_d = PhLen;
        end
      end
    endcase

    // Completed length: check zero and limit, else wait for flags
    if (len_done) begin
      phase_d = PhLen;
      if (len_sel == 64'd0) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_ZERO;
      end else if ({1'b0, len_sel} > max_p1_q) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_OVER;
      end else begin
        remain_d = len_sel - 64'd1;
        phase_d  = PhFlags;
      end
    end
  end

  // State registers, updated on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLen;
      shift_q  <= 64'd0;
      seen_q   <= 3'd0;
      remain_q <= 64'd0;
      flags_q  <= 8'd0;
      first_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      seen_q   <= seen_d;
      remain_q <= remain_d;
      flags_q  <= flags_d;
      first_q  <= first_d;
    end
  end

  // Limit register, stored as limit + 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_p1_q <= {1'b0, 64'hffff_ffff_ffff_ffff};
    end else if (cfg_we_i) begin
      max_p1_q <= {1'b0, cfg_wdata_i} + 65'd1;
    end
  end

endmodule

// ===== rtl/lpfd_out_buf.sv =====
// Two-entry output buffer (output register plus skid slot).
// Decouples downstream stall from input stall. Depends on lpfd_pkg.
module lpfd_out_buf import lpfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

  // Control: skid only fills when the output register is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= res_i;
      end else begin
        main_q <= res_i;
      end
    end
  end

endmodule

// ===== rtl/length_prefixed_frame_decoder.sv =====
// Top level of the length-prefixed frame decoder.
// Instantiates lpfd_parser and lpfd_out_buf; depends on lpfd_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   input    | in_valid_i / in_stall_o | stream_byte_i
//   output   | out_valid_o/out_stall_i | kind_o, body_byte_o, frame_flags_o,
//            |                        |   first_byte_o, last_byte_o
//   config   | cfg_we_i               | cfg_wdata_i (max body bytes)
//
// One byte per cycle while in_stall_o is low; a byte's result, if any, is registered in the output buffer.
// The parser decodes each byte combinationally; a two-entry output buffer
// keeps the input running while one result waits on a stalled output.
// in_stall_o rises only when both buffer entries are full.
// Reset is asynchronous, active low; the limit resets to 2^64-2.
module length_prefixed_frame_decoder import lpfd_pkg::*; #(
  parameter int unsigned LONG_LENGTH_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic [7:0]  frame_flags_o,
  output logic        first_byte_o,
  output logic        last_byte_o
);

  logic    accept;
  logic    res_valid;
  logic    buf_full;
  result_t res;
  result_t out_res;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  lpfd_parser #(
    .LONG_LENGTH_BYTES(LONG_LENGTH_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .stream_byte_i(stream_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lpfd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && res_valid),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_res)
  );

  assign kind_o        = out_res.kind;
  assign body_byte_o   = out_res.body_byte;
  assign frame_flags_o = out_res.frame_flags;
  assign first_byte_o  = out_res.first_byte;
  assign last_byte_o   = out_res.last_byte;

endmodule
